// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion, disabled while reset is asserted (active low).
`define DBPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DBPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DBPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define DBPM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/dbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Dot-bracket pair matcher package
// Transaction types, bracket and status codes, character decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dbpm_pkg;

  localparam int unsigned PosW = 11;

  localparam logic [7:0] ChRoundOpen   = 8'h28;
  localparam logic [7:0] ChRoundClose  = 8'h29;
  localparam logic [7:0] ChSquareOpen  = 8'h5B;
  localparam logic [7:0] ChSquareClose = 8'h5D;
  localparam logic [7:0] ChCurlyOpen   = 8'h7B;
  localparam logic [7:0] ChCurlyClose  = 8'h7D;
  localparam logic [7:0] ChColon       = 8'h3A;
  localparam logic [7:0] ChDot         = 8'h2E;

  typedef logic [PosW-1:0] pos_t;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNMATCHED = 2'd1,
    STAT_UNCLOSED  = 2'd2,
    STAT_TOO_LONG  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic    pair_valid;
    pos_t    open_pos;
    pos_t    close_pos;
    kind_e   bracket_kind;
    logic    end_of_string;
    status_e status;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_e kind;
  } char_class_t;

  function automatic char_class_t decode_char(logic [7:0] ch);
    char_class_t c;
    c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    unique case (ch) inside
      ChRoundOpen:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ROUND};
      ChSquareOpen:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      ChCurlyOpen:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      ChRoundClose:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ROUND};
      ChSquareClose: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      ChCurlyClose:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      ChColon, ChDot: c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
      default:       c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dbpm_cell.sv -----
// ----------------------------------------------------------------------------
// Stack cell
// One stack entry; takes the upper neighbor on push, the lower on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpm_cell (
  input  wire                 clk_i,
  input  dbpm_pkg::stack_ctl_t ctl_i,
  input  dbpm_pkg::pos_t      up_data_i,
  input  dbpm_pkg::pos_t      down_data_i,
  output dbpm_pkg::pos_t      data_o
);

  dbpm_pkg::pos_t data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      data_q <= up_data_i;
    end else if (ctl_i.pop) begin
      data_q <= down_data_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dbpm_stack.sv -----
// ----------------------------------------------------------------------------
// Shift stack
// Row of cells; the top of stack always sits in the first cell.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpm_stack #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire                  clk_i,
  input  dbpm_pkg::stack_ctl_t ctl_i,
  input  dbpm_pkg::pos_t       push_data_i,
  output dbpm_pkg::pos_t       top_o
);

  dbpm_pkg::pos_t cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dbpm_pkg::pos_t up_data;
    dbpm_pkg::pos_t down_data;

    if (i == 0) begin : g_top
      assign up_data = push_data_i;
    end else begin : g_mid_up
      assign up_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign down_data = '0;
    end else begin : g_mid_down
      assign down_data = cell_data[i+1];
    end

    dbpm_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl_i),
      .up_data_i  (up_data),
      .down_data_i(down_data),
      .data_o     (cell_data[i])
    );
  end

  assign top_o = cell_data[0];

endmodule

`default_nettype wire

// ----- hw/rtl/dot_bracket_pair_matcher.sv -----
// ----------------------------------------------------------------------------
// Dot-bracket pair matcher: one character per cycle unless stalled, result
// registered. Three shift stacks of cells give the top entry at a fixed place.
// Reset (async, low) empties stacks and result buffers; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dot_bracket_pair_matcher #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  dbpm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output dbpm_pkg::out_item_t out_data_o
);

  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam int unsigned NKind = 3;

  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] depth_q [NKind];
  logic [PW-1:0] depth_d [NKind];
  logic [PW-1:0] depth_step [NKind];
  dbpm_pkg::status_e err_q, err_d;

  dbpm_pkg::out_item_t out_q, skid_q, res;
  logic out_valid_q, skid_valid_q;

  dbpm_pkg::char_class_t cls;
  dbpm_pkg::stack_ctl_t  ctl [NKind];
  dbpm_pkg::pos_t        top [NKind];
  dbpm_pkg::pos_t        pos_trunc;
  dbpm_pkg::pos_t        top_sel;
  dbpm_pkg::status_e     err_step;
  dbpm_pkg::status_e     stat;
  logic [NKind-1:0]      empty, full, nonzero_after;
  logic [PW-1:0]         pos_inc;
  logic in_fire, out_fire, overlong, close_empty, close_ok, emit, push_res;

  assign in_ready_o = ~skid_valid_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = out_valid_q & out_ready_i;

  assign cls       = dbpm_pkg::decode_char(in_data_i.char_code);
  assign overlong  = (pos_q == PW'(MAX_LEN));
  assign pos_inc   = pos_q + 1'b1;
  assign pos_trunc = dbpm_pkg::pos_t'(pos_inc);

  for (genvar k = 0; k < NKind; k++) begin : g_kind
    logic sel;
    assign sel      = (cls.kind == dbpm_pkg::kind_e'(2'(k)));
    assign empty[k] = (depth_q[k] == '0);
    assign full[k]  = (depth_q[k] == PW'(MAX_LEN));
    assign ctl[k].push = in_fire & ~overlong & cls.is_open & sel & ~full[k];
    assign ctl[k].pop  = in_fire & ~overlong & cls.is_close & sel & ~empty[k];
    assign depth_step[k] = ctl[k].push ? depth_q[k] + 1'b1 :
                           ctl[k].pop  ? depth_q[k] - 1'b1 : depth_q[k];
    assign nonzero_after[k] = (depth_step[k] != '0);
    assign depth_d[k] = in_data_i.last_char ? '0 : depth_step[k];

    dbpm_stack #(.DEPTH(MAX_LEN)) u_stack (
      .clk_i      (clk_i),
      .ctl_i      (ctl[k]),
      .push_data_i(pos_trunc),
      .top_o      (top[k])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        depth_q[k] <= '0;
      end else if (in_fire) begin
        depth_q[k] <= depth_d[k];
      end
    end
  end

  always_comb begin
    case (cls.kind)
      dbpm_pkg::KIND_SQUARE: begin
        top_sel     = top[1];
        close_empty = empty[1];
      end
      dbpm_pkg::KIND_CURLY: begin
        top_sel     = top[2];
        close_empty = empty[2];
      end
      default: begin
        top_sel     = top[0];
        close_empty = empty[0];
      end
    endcase
  end

  always_comb begin
    close_ok = ~overlong & cls.is_close;
    err_step = err_q;
    if (err_q == dbpm_pkg::STAT_OK) begin
      if (overlong) begin
        err_step = dbpm_pkg::STAT_TOO_LONG;
      end else if (cls.is_close && close_empty) begin
        err_step = dbpm_pkg::STAT_UNMATCHED;
      end
    end
    stat = err_step;
    if (in_data_i.last_char && stat == dbpm_pkg::STAT_OK && |nonzero_after) begin
      stat = dbpm_pkg::STAT_UNCLOSED;
    end
    emit = overlong | cls.is_close | in_data_i.last_char;

    res.pair_valid    = close_ok & ~close_empty;
    res.open_pos      = res.pair_valid ? top_sel : '0;
    res.close_pos     = close_ok ? pos_trunc : '0;
    res.bracket_kind  = close_ok ? cls.kind : dbpm_pkg::KIND_ROUND;
    res.end_of_string = in_data_i.last_char;
    res.status        = stat;

    pos_d = in_data_i.last_char ? '0 : (overlong ? pos_q : pos_inc);
    err_d = in_data_i.last_char ? dbpm_pkg::STAT_OK : err_step;
  end

  assign push_res = in_fire & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      err_q <= dbpm_pkg::STAT_OK;
    end else if (in_fire) begin
      pos_q <= pos_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_res) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push_res) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DBPM_ASSERT(a_skid_implies_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid without output")
  `DBPM_ASSERT(a_depth_le_pos, clk_i, rst_ni, depth_q[0] <= pos_q, "round depth exceeds position")
  `DBPM_ASSERT(a_last_clears, clk_i, rst_ni, (in_fire && in_data_i.last_char) |=> (pos_q == '0), "position not cleared")
  `DBPM_ASSERT(a_overlong_emits, clk_i, rst_ni, (in_fire && overlong) |=> out_valid_q, "overlong without result")

endmodule

`default_nettype wire
